FILE: src/dgaps_pkg.sv
package dgaps_pkg;

  localparam int unsigned TEETH_W   = 8;
  localparam int unsigned READING_W = 16;
  localparam int unsigned OUT_W     = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TEETH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_TEETH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_LIMIT    = 2'd2;

  localparam logic [TEETH_W-1:0] FIRST_TEETH_RST  = 8'd32;
  localparam logic [TEETH_W-1:0] SECOND_TEETH_RST = 8'd39;
  localparam logic [TEETH_W-1:0] ROT_LIMIT_RST    = 8'd38;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_DIV,
    ST_BASE_DIV,
    ST_EVAL,
    ST_PICK,
    ST_OUT
  } dgaps_state_e;

endpackage

FILE: src/dual_gear_absolute_position_search.sv
// Each accepted item runs two passes of the shared bit-serial divider on a PW-bit dividend,
// where PW is max(ROTATION_BITS + FRACTION_BITS + 11, 26), that is at least 26. It then scans
// the rotation candidates 0 to rotation_limit, each in an EVAL and then a PICK state. A new
// item is accepted only in idle, after the last result has been taken.
// Reset loads the tooth counts 32 and 39 and the rotation limit 38, and idles.
module dual_gear_absolute_position_search #(
  parameter int unsigned FRACTION_BITS = 12,
  parameter int unsigned ROTATION_BITS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dgaps_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [dgaps_pkg::TEETH_W-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [dgaps_pkg::READING_W-1:0]  first_reading_i,
  input  logic signed [dgaps_pkg::READING_W-1:0]  second_reading_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [dgaps_pkg::OUT_W-1:0]      resolved_position_o
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned R   = ROTATION_BITS;
  localparam int unsigned TW  = dgaps_pkg::TEETH_W;
  localparam int unsigned RW  = dgaps_pkg::READING_W;
  localparam int unsigned CW  = (R + F + 2 > RW + 1) ? R + F + 2 : RW + 1;
  localparam int unsigned PW  = CW + TW + 1;
  localparam int unsigned DFW = ((F > RW) ? F : RW) + 2;

  dgaps_pkg::dgaps_state_e state_q, state_d;

  logic [TW-1:0] first_teeth_q;
  logic [TW-1:0] second_teeth_q;
  logic [TW-1:0] rot_limit_q;
  logic [TW-1:0] t2_eff;
  logic [R-1:0]  limit;

  logic signed [CW-1:0]  cand_q;
  logic signed [RW-1:0]  second_q;
  logic signed [PW-1:0]  prod_q;
  logic [F-1:0]          dq_q;
  logic [TW-1:0]         dr_q;
  logic [F-1:0]          q_q;
  logic [TW-1:0]         r_q;
  logic [F-1:0]          frac_q;
  logic [R-1:0]          idx_q;
  logic [DFW-1:0]        best_diff_q;
  logic signed [CW-1:0]  best_pos_q;

  logic                  div_start;
  logic [PW-1:0]         div_dividend;
  logic                  div_done;
  logic [PW-1:0]         div_quot;
  logic [TW-1:0]         div_rem;

  logic [PW-1:0]         prod_mag;
  logic signed [DFW-1:0] diff_s;
  logic [DFW-1:0]        diff_abs;
  logic                  better;
  logic [TW:0]           r_sum;
  logic                  r_wrap;
  logic                  in_acc;

  assign t2_eff = (second_teeth_q == '0) ? TW'(1) : second_teeth_q;
  assign limit  = R'(rot_limit_q);
  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_teeth_q  <= dgaps_pkg::FIRST_TEETH_RST;
      second_teeth_q <= dgaps_pkg::SECOND_TEETH_RST;
      rot_limit_q    <= dgaps_pkg::ROT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dgaps_pkg::REG_FIRST_TEETH:  first_teeth_q  <= cfg_data_i;
        dgaps_pkg::REG_SECOND_TEETH: second_teeth_q <= cfg_data_i;
        dgaps_pkg::REG_ROT_LIMIT:    rot_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign diff_s   = DFW'($signed({1'b0, frac_q})) - DFW'(second_q);
  assign diff_abs = diff_s[DFW-1] ? DFW'(-diff_s) : DFW'(diff_s);
  assign better   = (idx_q == '0) || (diff_abs < best_diff_q);
  assign r_sum    = {1'b0, r_q} + {1'b0, dr_q};
  assign r_wrap   = (r_sum >= {1'b0, t2_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dgaps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    div_start    = 1'b0;
    div_dividend = PW'(first_teeth_q) << F;
    case (state_q)
      dgaps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          div_start = 1'b1;
          state_d   = dgaps_pkg::ST_STEP_DIV;
        end
      end
      dgaps_pkg::ST_STEP_DIV: begin
        div_dividend = prod_mag;
        if (div_done) begin
          div_start = 1'b1;
          state_d   = dgaps_pkg::ST_BASE_DIV;
        end
      end
      dgaps_pkg::ST_BASE_DIV: begin
        if (div_done) begin
          state_d = dgaps_pkg::ST_EVAL;
        end
      end
      dgaps_pkg::ST_EVAL: begin
        state_d = dgaps_pkg::ST_PICK;
      end
      dgaps_pkg::ST_PICK: begin
        state_d = (idx_q == limit) ? dgaps_pkg::ST_OUT : dgaps_pkg::ST_EVAL;
      end
      dgaps_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = dgaps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dgaps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dgaps_pkg::ST_IDLE: begin
        if (in_acc) begin
          cand_q   <= CW'(first_reading_i) - (CW'(1) << F);
          second_q <= second_reading_i;
          idx_q    <= '0;
        end
      end
      dgaps_pkg::ST_STEP_DIV: begin
        prod_q <= PW'(cand_q) * PW'($signed({1'b0, first_teeth_q}));
        if (div_done) begin
          dq_q <= div_quot[F-1:0];
          dr_q <= div_rem;
        end
      end
      dgaps_pkg::ST_BASE_DIV: begin
        if (div_done) begin
          if (!prod_q[PW-1]) begin
            q_q <= div_quot[F-1:0];
            r_q <= div_rem;
          end else if (div_rem != '0) begin
            q_q <= ~div_quot[F-1:0];
            r_q <= t2_eff - div_rem;
          end else begin
            q_q <= -div_quot[F-1:0];
            r_q <= '0;
          end
        end
      end
      dgaps_pkg::ST_EVAL: begin
        frac_q <= q_q + F'(cand_q[CW-1] && (r_q != '0));
      end
      dgaps_pkg::ST_PICK: begin
        if (better) begin
          best_diff_q <= diff_abs;
          best_pos_q  <= cand_q;
        end
        cand_q <= cand_q + (CW'(1) << F);
        r_q    <= r_wrap ? TW'(r_sum - {1'b0, t2_eff}) : r_sum[TW-1:0];
        q_q    <= q_q + dq_q + F'(r_wrap);
        idx_q  <= idx_q + R'(1);
      end
      default: ;
    endcase
  end

  assign resolved_position_o = dgaps_pkg::OUT_W'(best_pos_q);

  dgaps_div #(
    .W(PW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (t2_eff),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

endmodule

FILE: src/dgaps_div.sv
module dgaps_div #(
  parameter int unsigned W = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [W-1:0]                      dividend_i,
  input  logic [dgaps_pkg::TEETH_W-1:0]     divisor_i,
  output logic                              done_o,
  output logic [W-1:0]                      quotient_o,
  output logic [dgaps_pkg::TEETH_W-1:0]     remainder_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);
  localparam int unsigned TW    = dgaps_pkg::TEETH_W;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     quot_q;
  logic [TW-1:0]    rem_q;
  logic [TW-1:0]    dsr_q;

  logic [TW:0]      trial;
  logic [TW:0]      diff;
  logic             fits;

  assign trial = {rem_q, quot_q[W-1]};
  assign fits  = (trial >= {1'b0, dsr_q});
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[W-2:0], fits};
      rem_q  <= fits ? diff[TW-1:0] : trial[TW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule
